// File: rtl/saq_pkg.sv
// saq_pkg: shared widths, codes and controller/datapath structs for the
// summed-area table query block. No dependencies.

package saq_pkg;

  localparam int DEF_MAX_ROWS = 64;
  localparam int DEF_MAX_COLS = 64;

  localparam int CNT_W     = 7;   // row/column counts and 1-based corners
  localparam int VALUE_W   = 16;
  localparam int SUM_W     = 28;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 1;

  localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(64);

  // operation codes
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_READY = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 1'd1;

  typedef struct packed {
    logic start_load;   // load item accepted
    logic load_rd;      // read entry above
    logic load_wr;      // write new entry, step position
    logic start_query;  // query item accepted
    logic qry_rd0;      // read right-hand corner pair
    logic qry_rd1;      // read left-hand corner pair
    logic qry_sum;      // combine left-hand pair
    logic out_load;     // write result register
  } saq_cmd_t;

  typedef struct packed {
    logic out_free;
  } saq_sts_t;

endpackage

// File: rtl/saq_ifs.sv
// saq_ifs: valid/ready channel interfaces for request, result and
// configuration. Depends on saq_pkg.

interface saq_req_if;
  import saq_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      func;
  logic signed [VALUE_W-1:0] value;
  logic [CNT_W-1:0]          top_row;
  logic [CNT_W-1:0]          left_col;
  logic [CNT_W-1:0]          bottom_row;
  logic [CNT_W-1:0]          right_col;
  modport source (output valid, func, value, top_row, left_col, bottom_row, right_col,
                  input ready);
  modport sink (input valid, func, value, top_row, left_col, bottom_row, right_col,
                output ready);
endinterface

interface saq_rsp_if;
  import saq_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [SUM_W-1:0] rect_sum;
  logic [STATUS_W-1:0]     status;
  modport source (output valid, rect_sum, status, input ready);
  modport sink (input valid, rect_sum, status, output ready);
endinterface

interface saq_cfg_if;
  import saq_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CNT_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/summed_area_table_query.sv
// summed_area_table_query: top level, joins saq_ctrl and saq_dp to the
// channel interfaces. Depends on saq_pkg, saq_ifs, saq_ctrl, saq_dp.
//
// Usage:
//   req  - items in: func 0 loads the next matrix element in row-major
//          order, func 1 asks for the sum of an inclusive rectangle with
//          1-based corners. Loads give no result item.
//   rsp  - one result item per query: rect_sum and status (ok, bad_range,
//          not_ready); rect_sum is zero unless status is ok.
//   cfg  - row_count (index 0) and col_count (index 1); a write restarts
//          loading at the first position and marks the table not ready.
//          Always ready; write only while the block is idle.
// Timing: one item at a time. A load reads the entry above, then writes.
//   A query reads the right-hand corner pair, then the left-hand pair, then
//   combines them and loads the result register once it is free; the next
//   item is taken after that. The four corner reads share the two read ports.
// Reset: counts return to 64, loading restarts, the table is not ready and
//   no result is pending. Table contents are not cleared.
// Stall: a result waits in the output register; a query finishing while it
//   is still held waits until it is taken.

module summed_area_table_query #(
  parameter int MAX_ROWS = saq_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = saq_pkg::DEF_MAX_COLS
) (
  input  logic       clk,
  input  logic       rst,
  saq_req_if.sink    req,
  saq_rsp_if.source  rsp,
  saq_cfg_if.sink    cfg
);

  import saq_pkg::*;

  saq_cmd_t cmd;
  saq_sts_t sts;
  logic     req_ready;

  assign req.ready = req_ready;
  assign cfg.ready = 1'b1;

  saq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_func  (req.func),
    .sts       (sts),
    .req_ready (req_ready),
    .cmd       (cmd)
  );

  saq_dp #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .value      (req.value),
    .top_row    (req.top_row),
    .left_col   (req.left_col),
    .bottom_row (req.bottom_row),
    .right_col  (req.right_col),
    .cfg_we     (cfg.valid),
    .cfg_index  (cfg.index),
    .cfg_data   (cfg.data),
    .rsp_ready  (rsp.ready),
    .rsp_valid  (rsp.valid),
    .rect_sum   (rsp.rect_sum),
    .status     (rsp.status)
  );

endmodule

// File: rtl/saq_ram.sv
// saq_ram: generic RAM, one write port and two registered read ports.
// No dependencies.

module saq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    ra_addr,
  output logic [WIDTH-1:0] ra_data,
  input  logic [AW-1:0]    rb_addr,
  output logic [WIDTH-1:0] rb_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    ra_data <= mem[ra_addr];
    rb_data <= mem[rb_addr];
  end

endmodule

// File: rtl/saq_ctrl.sv
// saq_ctrl: sequencing state machine for loads and rectangle queries.
// Depends on saq_pkg; drives the commands of saq_dp.

module saq_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  input  logic               req_func,
  input  saq_pkg::saq_sts_t  sts,
  output logic               req_ready,
  output saq_pkg::saq_cmd_t  cmd
);

  import saq_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_LD_RD  = 7'b0000010,
    S_LD_WR  = 7'b0000100,
    S_Q_RD0  = 7'b0001000,
    S_Q_RD1  = 7'b0010000,
    S_Q_SUM  = 7'b0100000,
    S_Q_DONE = 7'b1000000
  } state_t;

  state_t state, state_next;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          if (req_func == FUNC_LOAD) begin
            cmd.start_load = 1'b1;
            state_next     = S_LD_RD;
          end else begin
            cmd.start_query = 1'b1;
            state_next      = S_Q_RD0;
          end
        end
      end
      S_LD_RD: begin
        cmd.load_rd = 1'b1;
        state_next  = S_LD_WR;
      end
      S_LD_WR: begin
        cmd.load_wr = 1'b1;
        state_next  = S_IDLE;
      end
      S_Q_RD0: begin
        cmd.qry_rd0 = 1'b1;
        state_next  = S_Q_RD1;
      end
      S_Q_RD1: begin
        cmd.qry_rd1 = 1'b1;
        state_next  = S_Q_SUM;
      end
      S_Q_SUM: begin
        cmd.qry_sum = 1'b1;
        state_next  = S_Q_DONE;
      end
      S_Q_DONE: begin
        // hold until the result register can take the item
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: rtl/saq_dp.sv
// saq_dp: table memory, load position and running sum, query arithmetic
// and result register. Depends on saq_pkg and saq_ram.

module saq_dp #(
  parameter int MAX_ROWS = saq_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = saq_pkg::DEF_MAX_COLS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  saq_pkg::saq_cmd_t                   cmd,
  output saq_pkg::saq_sts_t                   sts,
  input  logic signed [saq_pkg::VALUE_W-1:0]  value,
  input  logic [saq_pkg::CNT_W-1:0]           top_row,
  input  logic [saq_pkg::CNT_W-1:0]           left_col,
  input  logic [saq_pkg::CNT_W-1:0]           bottom_row,
  input  logic [saq_pkg::CNT_W-1:0]           right_col,
  input  logic                                cfg_we,
  input  logic [saq_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [saq_pkg::CNT_W-1:0]           cfg_data,
  input  logic                                rsp_ready,
  output logic                                rsp_valid,
  output logic signed [saq_pkg::SUM_W-1:0]    rect_sum,
  output logic [saq_pkg::STATUS_W-1:0]        status
);

  import saq_pkg::*;

  localparam int DEPTH   = MAX_ROWS * MAX_COLS;
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_MAX = (1 << CNT_W) - 1;
  localparam int ROW_LIM = (MAX_ROWS < CNT_MAX) ? MAX_ROWS : CNT_MAX;
  localparam int COL_LIM = (MAX_COLS < CNT_MAX) ? MAX_COLS : CNT_MAX;

  localparam logic [CNT_W-1:0] ROW_LIM_C = CNT_W'(ROW_LIM);
  localparam logic [CNT_W-1:0] COL_LIM_C = CNT_W'(COL_LIM);
  localparam logic [CNT_W-1:0] ONE       = CNT_W'(1);
  localparam logic [CNT_W-1:0] TWO       = CNT_W'(2);
  localparam logic [AW-1:0]    COLS_A    = AW'(MAX_COLS);

  // configuration and load state
  logic [CNT_W-1:0] row_count;
  logic [CNT_W-1:0] col_count;
  logic [CNT_W-1:0] load_row;
  logic [CNT_W-1:0] load_col;
  logic [SUM_W-1:0] run_sum;
  logic             table_ready;

  // per-item working registers
  logic [CNT_W-1:0]    ld_r;
  logic [CNT_W-1:0]    ld_c;
  logic [CNT_W-1:0]    q_t;
  logic [CNT_W-1:0]    q_l;
  logic [CNT_W-1:0]    q_b;
  logic [CNT_W-1:0]    q_r;
  logic [STATUS_W-1:0] q_status;
  logic [SUM_W-1:0]    p1;
  logic [SUM_W-1:0]    p2;

  logic [CNT_W-1:0] rows;
  logic [CNT_W-1:0] cols;
  logic             pos_wrap;
  logic             bad_range;
  logic [CNT_W:0]   ld_c_inc;
  logic [CNT_W:0]   ld_r_inc;

  logic [AW-1:0]    ra_addr;
  logic [AW-1:0]    rb_addr;
  logic [AW-1:0]    waddr;
  logic [SUM_W-1:0] wdata;
  logic [SUM_W-1:0] rd_a;
  logic [SUM_W-1:0] rd_b;
  logic [SUM_W-1:0] rb_data_w;

  function automatic logic [AW-1:0] ent_addr(input logic [CNT_W-1:0] r,
                                             input logic [CNT_W-1:0] c);
    return AW'(AW'(r) * COLS_A + AW'(c));
  endfunction

  // counts of zero act as one, counts above the maximum as the maximum
  assign rows = (row_count == '0) ? ONE : ((row_count > ROW_LIM_C) ? ROW_LIM_C : row_count);
  assign cols = (col_count == '0) ? ONE : ((col_count > COL_LIM_C) ? COL_LIM_C : col_count);

  assign pos_wrap  = (load_row >= rows) || (load_col >= cols);
  assign bad_range = (top_row == '0) || (left_col == '0) ||
                     (top_row > bottom_row) || (left_col > right_col) ||
                     (bottom_row > rows) || (right_col > cols);

  assign ld_c_inc = {1'b0, ld_c} + (CNT_W+1)'(1);
  assign ld_r_inc = {1'b0, ld_r} + (CNT_W+1)'(1);

  assign sts.out_free = !rsp_valid || rsp_ready;

  // read ports: entry above on a load, corner pairs on a query
  always_comb begin
    ra_addr = ent_addr(q_b - ONE, q_r - ONE);
    rb_addr = ent_addr(q_t - TWO, q_r - ONE);
    if (cmd.load_rd) begin
      ra_addr = ent_addr(ld_r - ONE, ld_c);
    end
    if (cmd.qry_rd1) begin
      ra_addr = ent_addr(q_b - ONE, q_l - TWO);
      rb_addr = ent_addr(q_t - TWO, q_l - TWO);
    end
  end

  assign waddr = ent_addr(ld_r, ld_c);
  assign wdata = run_sum + ((ld_r == '0) ? '0 : rd_a);

  saq_ram #(
    .WIDTH (SUM_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk     (clk),
    .we      (cmd.load_wr),
    .waddr   (waddr),
    .wdata   (wdata),
    .ra_addr (ra_addr),
    .ra_data (rd_a),
    .rb_addr (rb_addr),
    .rb_data (rb_data_w)
  );

  assign rd_b = rb_data_w;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count   <= CNT_RESET;
      col_count   <= CNT_RESET;
      load_row    <= '0;
      load_col    <= '0;
      run_sum     <= '0;
      table_ready <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROW_COUNT: row_count <= cfg_data;
        REG_COL_COUNT: col_count <= cfg_data;
      endcase
      load_row    <= '0;
      load_col    <= '0;
      run_sum     <= '0;
      table_ready <= 1'b0;
    end else if (cmd.start_load) begin
      run_sum <= (pos_wrap ? '0 : run_sum) + SUM_W'(value);
    end else if (cmd.load_wr) begin
      if (ld_c_inc < {1'b0, cols}) begin
        load_col    <= ld_c_inc[CNT_W-1:0];
        load_row    <= ld_r;
        table_ready <= 1'b0;
      end else begin
        load_col <= '0;
        run_sum  <= '0;
        if (ld_r_inc < {1'b0, rows}) begin
          load_row    <= ld_r_inc[CNT_W-1:0];
          table_ready <= 1'b0;
        end else begin
          load_row    <= '0;
          table_ready <= 1'b1;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.start_load) begin
      ld_r <= pos_wrap ? '0 : load_row;
      ld_c <= pos_wrap ? '0 : load_col;
    end
    if (cmd.start_query) begin
      q_t <= top_row;
      q_l <= left_col;
      q_b <= bottom_row;
      q_r <= right_col;
      if (!table_ready) begin
        q_status <= ST_NOT_READY;
      end else if (bad_range) begin
        q_status <= ST_BAD_RANGE;
      end else begin
        q_status <= ST_OK;
      end
    end
    // row zero and column zero of the 1-based table read as zero
    if (cmd.qry_rd1) begin
      p1 <= rd_a - ((q_t == ONE) ? '0 : rd_b);
    end
    if (cmd.qry_sum) begin
      p2 <= (((q_t == ONE) || (q_l == ONE)) ? '0 : rd_b) - ((q_l == ONE) ? '0 : rd_a);
    end
    if (cmd.out_load) begin
      rect_sum <= (q_status == ST_OK) ? $signed(p1 + p2) : '0;
      status   <= q_status;
    end
  end

endmodule

// File: rtl/saq_checker.sv
// saq_checker: port-level assertions for summed_area_table_query, bound to
// the top level. Depends on saq_pkg and the top level's ports.

module saq_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               req_valid,
  input logic                               req_ready,
  input logic                               req_func,
  input logic                               rsp_valid,
  input logic                               rsp_ready,
  input logic signed [saq_pkg::SUM_W-1:0]   rect_sum,
  input logic [saq_pkg::STATUS_W-1:0]       status
);

  import saq_pkg::*;

  // a valid result's status is always one of the three defined codes
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (status == ST_OK || status == ST_BAD_RANGE || status == ST_NOT_READY))
    else $error("result status code undefined");

  // a refused query carries a zero sum
  a_zero_on_error: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && status != ST_OK) |-> (rect_sum == '0))
    else $error("nonzero sum with error status");

  // a load never makes a result appear
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready && req_func == FUNC_LOAD) |=> !$rose(rsp_valid))
    else $error("result produced by a load");

  // held result stays put while the receiver stalls
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rect_sum) && $stable(status)))
    else $error("stalled result changed");

endmodule

bind summed_area_table_query saq_checker u_saq_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .req_func  (req.func),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rect_sum  (rsp.rect_sum),
  .status    (rsp.status)
);
